FILE: design/rlcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the rigid link constraint block.
package rlcm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int MAG_W        = DIFF_W;
  localparam int NORM_MSB     = 30;
  localparam int VEC_W        = FRAC_BITS + 4;
  localparam int VAL_W        = 48;
  localparam int ROW_W        = 4;
  localparam int COL_W        = 5;
  localparam int WIDE_W       = 64;
  localparam int QUOT_W       = FRAC_BITS + 1;
  localparam int SQRT_STEPS   = 32;
  localparam int CROSS_STEPS  = 18;
  localparam int PROD_W       = DIFF_W + VEC_W;
  localparam int CNT_W        = 6;
  localparam int NZ_ENTRIES   = 30;
  localparam int ZL_ENTRIES   = 12;

  localparam logic [COL_W-1:0] COL_AXIS = 5'd12;
  localparam logic [COL_W-1:0] COL_TRAN = 5'd13;
  localparam logic [COL_W-1:0] COL_V2   = 5'd16;
  localparam logic [COL_W-1:0] COL_V3   = 5'd17;

  localparam logic [2:0] JOB_C1_FIRST = 3'd0;
  localparam logic [2:0] JOB_C1_LAST  = 3'd2;
  localparam logic [2:0] JOB_C2_FIRST = 3'd3;
  localparam logic [2:0] JOB_C2_LAST  = 3'd4;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  zero;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_SQUARE, ST_SQRT, ST_DIV_LOAD, ST_DIV, ST_CROSS, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SRC_C1, SRC_C1_NEG, SRC_ONE, SRC_ONE_NEG, SRC_VEC, SRC_VEC_NEG, SRC_MOMENT
  } src_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    src_t             src;
    logic [1:0]       idx;
  } entry_t;

endpackage

FILE: design/rlcm_front.sv
`timescale 1ns / 1ps
// Front end: accept a link, form the node difference and flag a zero-length link.
module rlcm_front
  import rlcm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_first_z,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_second_z,
  output logic                      push_valid,
  input  logic                      push_ready,
  output link_t                     push_data
);

  logic  hold_valid_r, hold_valid_nxt;
  link_t link_r, link_nxt;
  logic  accept;

  assign in_ready   = !hold_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = link_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    link_nxt       = link_r;
    if (hold_valid_r && push_ready) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = 1'b1;
      link_nxt.dx    = diff_t'(in_second_x) - diff_t'(in_first_x);
      link_nxt.dy    = diff_t'(in_second_y) - diff_t'(in_first_y);
      link_nxt.dz    = diff_t'(in_second_z) - diff_t'(in_first_z);
      link_nxt.zero  = (in_second_x == in_first_x) && (in_second_y == in_first_y) &&
                       (in_second_z == in_first_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

endmodule

FILE: design/rlcm_queue.sv
`timescale 1ns / 1ps
// Short link queue between the front end and the back end.
module rlcm_queue
  import rlcm_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  link_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output link_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  link_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_QW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/rlcm_back.sv
`timescale 1ns / 1ps
// Back end: frame vectors by shared square root, divide and cross product, then stream entries.
module rlcm_back
  import rlcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  link_t                   q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row_index,
  output logic [COL_W-1:0]        out_col_index,
  output logic signed [VAL_W-1:0] out_entry_value,
  output logic                    out_zero_length,
  output logic                    out_last_entry
);

  localparam logic [WIDE_W-1:0] SQRT_BIT0 = WIDE_W'(1) << (WIDE_W - 2);
  localparam logic [PROD_W:0]   RND_HALF  = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam val_t              ONE_VAL   = val_t'(1) << FRAC_BITS;
  localparam logic [QUOT_W-1:0] QUOT_MAX  = QUOT_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [1:0] k;
    logic [1:0] j;
    logic       half;
  } xstep_t;

  function automatic logic [1:0] mod3_add(logic [1:0] i, logic [1:0] k);
    logic [2:0] s;
    s = 3'(i) + 3'(k);
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  function automatic xstep_t xdec(logic [CNT_W-1:0] s);
    xstep_t           r;
    logic [CNT_W-1:0] t;
    if (s >= CNT_W'(12)) begin
      r.k = 2'd2;
      t   = s - CNT_W'(12);
    end else if (s >= CNT_W'(6)) begin
      r.k = 2'd1;
      t   = s - CNT_W'(6);
    end else begin
      r.k = 2'd0;
      t   = s;
    end
    r.j    = t[2:1];
    r.half = t[0];
    return r;
  endfunction

  function automatic val_t round_frac(logic signed [PROD_W:0] x);
    logic [PROD_W:0] mag;
    logic [PROD_W:0] sh;
    mag = x[PROD_W] ? (PROD_W + 1)'(-x) : (PROD_W + 1)'(x);
    sh  = (mag + RND_HALF) >> FRAC_BITS;
    return x[PROD_W] ? -val_t'(sh) : val_t'(sh);
  endfunction

  function automatic entry_t ent(logic [CNT_W-1:0] c, logic zl);
    entry_t           e;
    logic [CNT_W-1:0] q;
    logic [CNT_W-1:0] t;
    e.row = '0;
    e.col = COL_AXIS;
    e.src = SRC_ONE;
    e.idx = '0;
    q     = '0;
    t     = '0;
    if (zl) begin
      e.row = ROW_W'(c[3:1]) + (c[0] ? ROW_W'(6) : ROW_W'(0));
      e.col = COL_AXIS + COL_W'(c[3:1]);
      e.src = c[0] ? SRC_ONE_NEG : SRC_ONE;
    end else if (c < CNT_W'(3)) begin
      e.row = ROW_W'(c);
      e.src = SRC_C1;
      e.idx = c[1:0];
    end else if (c < CNT_W'(6)) begin
      q     = c - CNT_W'(3);
      e.row = ROW_W'(c) + ROW_W'(3);
      e.src = SRC_C1_NEG;
      e.idx = q[1:0];
    end else if (c < CNT_W'(12)) begin
      q     = c - CNT_W'(6);
      e.row = ROW_W'(q[2:1]) + (q[0] ? ROW_W'(9) : ROW_W'(3));
      e.col = COL_TRAN + COL_W'(q[2:1]);
      e.src = q[0] ? SRC_ONE_NEG : SRC_ONE;
    end else begin
      q = c - CNT_W'(12);
      if (q >= CNT_W'(9)) begin
        e.col = COL_V3;
        t     = q - CNT_W'(9);
      end else begin
        e.col = COL_V2;
        t     = q;
      end
      e.row = ROW_W'(t);
      if (t < CNT_W'(3)) begin
        e.src = SRC_VEC;
        e.idx = t[1:0];
      end else if (t < CNT_W'(6)) begin
        q     = t - CNT_W'(3);
        e.src = SRC_MOMENT;
        e.idx = q[1:0];
      end else begin
        q     = t - CNT_W'(6);
        e.src = SRC_VEC_NEG;
        e.idx = q[1:0];
      end
    end
    return e;
  endfunction

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     phase_r, phase_nxt;
  logic [2:0]               job_r, job_nxt;
  logic                     zero_r, zero_nxt;
  logic                     sel_r, sel_nxt;
  diff_t                    d_r [3];
  diff_t                    d_nxt [3];
  logic [MAG_W-1:0]         m_r [3];
  logic [MAG_W-1:0]         m_nxt [3];
  logic [WIDE_W-1:0]        acc_r, acc_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [WIDE_W-1:0]        rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [MAG_W-1:0]         den_r, den_nxt;
  logic [QUOT_W-1:0]        quo_r, quo_nxt;
  vec_t                     c1_r [3];
  vec_t                     c1_nxt [3];
  vec_t                     c2_r [3];
  vec_t                     c2_nxt [3];
  vec_t                     c3_r [3];
  vec_t                     c3_nxt [3];
  val_t                     r16_r [3];
  val_t                     r16_nxt [3];
  val_t                     r17_r [3];
  val_t                     r17_nxt [3];
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W:0]   cacc_r, cacc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]         out_row_r, out_row_nxt;
  logic [COL_W-1:0]         out_col_r, out_col_nxt;
  val_t                     out_val_r, out_val_nxt;
  logic                     out_zero_r, out_zero_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [MAG_W-1:0]         mx;
  logic [1:0]               sq_idx;
  logic [WIDE_W-1:0]        sq_val;
  logic [WIDE_W-1:0]        sq_try;
  logic [1:0]               num_idx;
  logic                     num_neg;
  logic [WIDE_W-1:0]        num_val;
  logic [QUOT_W-1:0]        quo_fin;
  vec_t                     div_res;
  xstep_t                   xs, ps;
  logic [1:0]               xi, yi;
  diff_t                    xop;
  vec_t                     yop;
  val_t                     cres;
  entry_t                   en;
  vec_t                     vsrc;
  val_t                     mom;
  val_t                     eval;
  logic                     elast;
  logic                     out_adv;

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_entry_value = out_val_r;
  assign out_zero_length = out_zero_r;
  assign out_last_entry  = out_last_r;
  assign out_adv         = !out_valid_r || out_ready;

  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) begin
      mx = m_r[1];
    end
    if (m_r[2] > mx) begin
      mx = m_r[2];
    end
  end

  always_comb begin
    if (phase_r) begin
      sq_idx = cnt_r[0] ? (sel_r ? 2'd1 : 2'd2) : 2'd0;
    end else begin
      sq_idx = cnt_r[1:0];
    end
    sq_val = WIDE_W'(m_r[sq_idx][NORM_MSB:0]) * WIDE_W'(m_r[sq_idx][NORM_MSB:0]);
    sq_try = root_r + bit_r;
  end

  always_comb begin
    num_idx = job_r[1:0];
    num_neg = d_r[job_r[1:0]][DIFF_W-1];
    if (job_r == JOB_C2_FIRST) begin
      num_idx = sel_r ? 2'd1 : 2'd2;
      num_neg = sel_r ? (!d_r[1][DIFF_W-1] && d_r[1] != '0) : d_r[2][DIFF_W-1];
    end else if (job_r == JOB_C2_LAST) begin
      num_idx = 2'd0;
      num_neg = sel_r ? d_r[0][DIFF_W-1] : (!d_r[0][DIFF_W-1] && d_r[0] != '0);
    end
    num_val = (WIDE_W'(m_r[num_idx]) << FRAC_BITS) + WIDE_W'(den_r >> 1);
  end

  always_comb begin
    en    = ent(cnt_r, zero_r);
    vsrc  = (en.col == COL_V3) ? c3_r[en.idx] : c2_r[en.idx];
    mom   = (en.col == COL_V3) ? r17_r[en.idx] : r16_r[en.idx];
    elast = cnt_r == (zero_r ? CNT_W'(ZL_ENTRIES - 1) : CNT_W'(NZ_ENTRIES - 1));
    case (en.src)
      SRC_C1:      eval = val_t'(c1_r[en.idx]);
      SRC_C1_NEG:  eval = -val_t'(c1_r[en.idx]);
      SRC_ONE:     eval = ONE_VAL;
      SRC_ONE_NEG: eval = -ONE_VAL;
      SRC_VEC:     eval = val_t'(vsrc);
      SRC_VEC_NEG: eval = -val_t'(vsrc);
      SRC_MOMENT:  eval = mom;
      default:     eval = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    job_nxt       = job_r;
    zero_nxt      = zero_r;
    sel_nxt       = sel_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    r16_nxt       = r16_r;
    r17_nxt       = r17_r;
    prod_nxt      = prod_r;
    cacc_nxt      = cacc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_val_nxt   = out_val_r;
    out_zero_nxt  = out_zero_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    quo_fin       = '0;
    div_res       = '0;
    xs            = '0;
    ps            = '0;
    xi            = '0;
    yi            = '0;
    xop           = '0;
    yop           = '0;
    cres          = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          d_nxt[0] = q_data.dx;
          d_nxt[1] = q_data.dy;
          d_nxt[2] = q_data.dz;
          for (int i = 0; i < 3; i++) begin
            m_nxt[i] = d_nxt[i][DIFF_W-1] ? MAG_W'(-d_nxt[i]) : MAG_W'(d_nxt[i]);
          end
          zero_nxt  = q_data.zero;
          cnt_nxt   = '0;
          state_nxt = q_data.zero ? ST_EMIT : ST_NORM;
        end
      end
      ST_NORM: begin
        if (mx[MAG_W-1:NORM_MSB+1] != '0) begin
          for (int i = 0; i < 3; i++) begin
            m_nxt[i] = m_r[i] >> 1;
          end
        end else if (!mx[NORM_MSB]) begin
          for (int i = 0; i < 3; i++) begin
            m_nxt[i] = m_r[i] << 1;
          end
        end else begin
          sel_nxt   = m_r[1] > m_r[2];
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        acc_nxt = acc_r + sq_val;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (phase_r ? CNT_W'(1) : CNT_W'(2))) begin
          root_nxt  = '0;
          bit_nxt   = SQRT_BIT0;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (acc_r >= sq_try) begin
          acc_nxt  = acc_r - sq_try;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          den_nxt   = root_nxt[MAG_W-1:0];
          job_nxt   = phase_r ? JOB_C2_FIRST : JOB_C1_FIRST;
          state_nxt = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        rem_nxt   = num_val;
        dsh_nxt   = WIDE_W'(den_r) << (QUOT_W - 1);
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          quo_nxt = {quo_r[QUOT_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[QUOT_W-2:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          quo_fin = quo_nxt;
          if (job_r <= JOB_C1_LAST && quo_fin > QUOT_MAX) begin
            quo_fin = QUOT_MAX;
          end
          div_res = num_neg ? -vec_t'(quo_fin) : vec_t'(quo_fin);
          if (job_r <= JOB_C1_LAST) begin
            c1_nxt[job_r[1:0]] = div_res;
          end else if (job_r == JOB_C2_FIRST) begin
            c2_nxt[0] = div_res;
            c2_nxt[sel_r ? 2'd2 : 2'd1] = '0;
          end else begin
            c2_nxt[sel_r ? 2'd1 : 2'd2] = div_res;
          end
          if (job_r == JOB_C1_LAST) begin
            phase_nxt = 1'b1;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_SQUARE;
          end else if (job_r == JOB_C2_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_CROSS;
          end else begin
            job_nxt   = job_r + 1'b1;
            state_nxt = ST_DIV_LOAD;
          end
        end
      end
      ST_CROSS: begin
        if (cnt_r < CNT_W'(CROSS_STEPS)) begin
          xs       = xdec(cnt_r);
          xi       = xs.half ? mod3_add(xs.j, 2'd2) : mod3_add(xs.j, 2'd1);
          yi       = xs.half ? mod3_add(xs.j, 2'd1) : mod3_add(xs.j, 2'd2);
          xop      = (xs.k == 2'd0) ? diff_t'(c1_r[xi]) : d_r[xi];
          yop      = (xs.k == 2'd2) ? c3_r[yi] : c2_r[yi];
          prod_nxt = PROD_W'(xop) * PROD_W'(yop);
        end
        if (cnt_r != '0) begin
          ps = xdec(cnt_r - 1'b1);
          if (!ps.half) begin
            cacc_nxt = (PROD_W + 1)'(prod_r);
          end else begin
            cres = round_frac(cacc_r - (PROD_W + 1)'(prod_r));
            case (ps.k)
              2'd0:    c3_nxt[ps.j] = vec_t'(cres);
              2'd1:    r16_nxt[ps.j] = cres;
              default: r17_nxt[ps.j] = cres;
            endcase
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CROSS_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_adv) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = en.row;
          out_col_nxt   = en.col;
          out_val_nxt   = eval;
          out_zero_nxt  = zero_r;
          out_last_nxt  = elast;
          cnt_nxt       = cnt_r + 1'b1;
          if (elast) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      job_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r     <= zero_nxt;
    sel_r      <= sel_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    acc_r      <= acc_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    c1_r       <= c1_nxt;
    c2_r       <= c2_nxt;
    c3_r       <= c3_nxt;
    r16_r      <= r16_nxt;
    r17_r      <= r17_nxt;
    prod_r     <= prod_nxt;
    cacc_r     <= cacc_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_val_r  <= out_val_nxt;
    out_zero_r <= out_zero_nxt;
    out_last_r <= out_last_nxt;
  end

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_col_r == COL_V3)
    else $error("last beat of a link not in the final column");

  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> (out_val_r == ONE_VAL || out_val_r == -ONE_VAL))
    else $error("zero-length beat carries a value other than plus or minus one");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQUARE |-> mx[MAG_W-1:NORM_MSB] == 3'b001)
    else $error("axis magnitudes not normalized before squaring");

endmodule

FILE: design/rigid_link_constraint_matrix.sv
`timescale 1ns / 1ps
// Top level of the rigid link constraint matrix generator.
// Takes the two end nodes of a rigid link (signed Q16.16) and streams the
// nonzero upper-block entries (rows 0-11, columns 12-17) of the 18x18
// constraint matrix, one entry per output beat, last_entry on the final one.
// A zero-length link gives 12 beats of +1/-1 with zero_length set. A link of
// nonzero length gives 30 beats after axis normalization, five squarings,
// two 32-step square roots, five divides and the cross products on one
// multiplier; the receiver can hold off any beat. The shared square root
// and divide each resolve one bit per cycle. A front register and a short
// link queue take new links while the back end is busy.
module rigid_link_constraint_matrix
  import rlcm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_first_z,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_second_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ROW_W-1:0]          out_row_index,
  output logic [COL_W-1:0]          out_col_index,
  output logic signed [VAL_W-1:0]   out_entry_value,
  output logic                      out_zero_length,
  output logic                      out_last_entry
);

  logic  push_valid, push_ready, pop_valid, pop;
  link_t push_data, pop_data;

  rlcm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_first_z  (in_first_z),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .in_second_z (in_second_z),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  rlcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  rlcm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_entry_value (out_entry_value),
    .out_zero_length (out_zero_length),
    .out_last_entry  (out_last_entry)
  );

endmodule

FILE: verif/tb_rigid_link_constraint_matrix.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rigid link constraint matrix generator.
module tb_rigid_link_constraint_matrix;
  import rlcm_pkg::*;

  localparam int F = FRAC_BITS;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
  } link_beat_t;

  typedef struct {
    logic [3:0]         row;
    logic [4:0]         col;
    logic signed [47:0] val;
    logic               zl;
    logic               last;
  } entry_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_W-1:0] out_row_index;
  logic [COL_W-1:0] out_col_index;
  logic signed [VAL_W-1:0] out_entry_value;
  logic out_zero_length, out_last_entry;

  link_beat_t  pending_links[$];
  entry_beat_t expected_entries[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_off = 0;
  bit          pause_send = 1'b0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;

  rigid_link_constraint_matrix dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_frac(input longint v);
    longint m;
    m = (mag(v) + (longint'(1) << (F - 1))) >>> F;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_nearest(input longint n, input longint d);
    longint m;
    m = (mag(n) + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic push_entry(input int row, input int col, input longint val,
                            input bit zl);
    entry_beat_t e;
    e.row = row[3:0];
    e.col = col[4:0];
    e.val = val[47:0];
    e.zl = zl;
    e.last = 1'b0;
    expected_entries.push_back(e);
  endtask

  task automatic predict_entries(input link_beat_t lk);
    longint one, d[3], m[3], a[3], c1[3], c2[3], c3[3], v[3], mx, len, nrm;
    one = longint'(1) << F;
    d[0] = longint'(lk.sx) - longint'(lk.fx);
    d[1] = longint'(lk.sy) - longint'(lk.fy);
    d[2] = longint'(lk.sz) - longint'(lk.fz);
    for (int i = 0; i < 3; i++) m[i] = mag(d[i]);
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
      for (int i = 0; i < 6; i++) begin
        push_entry(i, 12 + i, one, 1'b1);
        push_entry(6 + i, 12 + i, -one, 1'b1);
      end
    end else begin
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      while (mx >= (longint'(1) << 31)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (longint'(1) << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) a[i] = d[i] < 0 ? -m[i] : m[i];
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        c1[i] = div_nearest(a[i] * one, len);
        if (c1[i] > one) c1[i] = one;
        if (c1[i] < -one) c1[i] = -one;
      end
      if (m[1] > m[2]) begin
        nrm = int_sqrt(m[0] * m[0] + m[1] * m[1]);
        c2[0] = div_nearest(-a[1] * one, nrm);
        c2[1] = div_nearest(a[0] * one, nrm);
        c2[2] = 0;
      end else begin
        nrm = int_sqrt(m[0] * m[0] + m[2] * m[2]);
        c2[0] = div_nearest(a[2] * one, nrm);
        c2[1] = 0;
        c2[2] = div_nearest(-a[0] * one, nrm);
      end
      c3[0] = round_frac(c1[1] * c2[2] - c1[2] * c2[1]);
      c3[1] = round_frac(c1[2] * c2[0] - c1[0] * c2[2]);
      c3[2] = round_frac(c1[0] * c2[1] - c1[1] * c2[0]);
      for (int i = 0; i < 3; i++) push_entry(i, 12, c1[i], 1'b0);
      for (int i = 0; i < 3; i++) push_entry(6 + i, 12, -c1[i], 1'b0);
      for (int i = 0; i < 3; i++) begin
        push_entry(3 + i, 13 + i, one, 1'b0);
        push_entry(9 + i, 13 + i, -one, 1'b0);
      end
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) v[i] = k == 0 ? c2[i] : c3[i];
        push_entry(0, 16 + k, v[0], 1'b0);
        push_entry(1, 16 + k, v[1], 1'b0);
        push_entry(2, 16 + k, v[2], 1'b0);
        push_entry(3, 16 + k, round_frac(-v[1] * d[2] + v[2] * d[1]), 1'b0);
        push_entry(4, 16 + k, round_frac(v[0] * d[2] - v[2] * d[0]), 1'b0);
        push_entry(5, 16 + k, round_frac(-v[0] * d[1] + v[1] * d[0]), 1'b0);
        push_entry(6, 16 + k, -v[0], 1'b0);
        push_entry(7, 16 + k, -v[1], 1'b0);
        push_entry(8, 16 + k, -v[2], 1'b0);
      end
    end
    expected_entries[$].last = 1'b1;
  endtask

  // receiver hold-off count
  always @(negedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_entries(pending_links.pop_front());
        send_gap = $urandom_range(0, 4);
      end
      if (in_valid && !in_taken) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (!pause_send && pending_links.size() > 0) begin
        in_first_x <= pending_links[0].fx;
        in_first_y <= pending_links[0].fy;
        in_first_z <= pending_links[0].fz;
        in_second_x <= pending_links[0].sx;
        in_second_y <= pending_links[0].sy;
        in_second_z <= pending_links[0].sz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
      end else if (out_taken) begin
        recv_gap = $urandom_range(0, 4);
        out_ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_ready <= (recv_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    entry_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected entry beat");
      end else begin
        e = expected_entries.pop_front();
        if (out_row_index !== e.row)
          report_mismatch($sformatf("row %0d exp %0d", out_row_index, e.row));
        if (out_col_index !== e.col)
          report_mismatch($sformatf("col %0d exp %0d", out_col_index, e.col));
        if (out_entry_value !== e.val)
          report_mismatch($sformatf("value %0d exp %0d (r%0d c%0d)",
                                    out_entry_value, e.val, e.row, e.col));
        if (out_zero_length !== e.zl)
          report_mismatch($sformatf("zero_length %0b exp %0b", out_zero_length, e.zl));
        if (out_last_entry !== e.last)
          report_mismatch($sformatf("last_entry %0b exp %0b", out_last_entry, e.last));
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_link(input logic signed [31:0] fx, fy, fz, sx, sy, sz);
    link_beat_t lk;
    lk.fx = fx; lk.fy = fy; lk.fz = fz;
    lk.sx = sx; lk.sy = sy; lk.sz = sz;
    pending_links.push_back(lk);
  endtask

  task automatic wait_drained();
    while (pending_links.size() > 0 || in_valid || expected_entries.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    link_beat_t lk;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed links
    add_link(0, 0, 0, 0, 0, 0);
    add_link(32'sh7fffffff, 5, -5, 32'sh7fffffff, 5, -5);
    add_link(0, 0, 0, 32'sh10000, 0, 0);
    add_link(0, 0, 0, 0, 32'sh10000, 0);
    add_link(0, 0, 0, 0, 0, 32'sh10000);
    add_link(0, 0, 0, 1, 1, 1);
    add_link(0, 0, 0, 1, 2, 2);
    add_link(0, 0, 0, 3, 5, 4);
    add_link(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_link(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_link(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0);
    add_link(0, 0, 0, 0, 0, -1);
    add_link(-1, -1, -1, 0, 0, 0);
    add_link(32'shffffffff, 32'h55555555, 32'shaaaaaaaa, 0, 1, 2);
    wait_drained();
    // long receiver hold-off while links keep coming
    hold_off = 3000;
    for (int i = 0; i < 8; i++)
      add_link(rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord());
    wait_drained();
    for (int i = 0; i < 240; i++) begin
      lk.fx = rand_coord(); lk.fy = rand_coord(); lk.fz = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
        lk.sx = lk.fx; lk.sy = lk.fy; lk.sz = lk.fz;
      end else begin
        lk.sx = rand_coord(); lk.sy = rand_coord(); lk.sz = rand_coord();
        if ($urandom_range(0, 4) == 0) lk.sy = lk.fy;
        if ($urandom_range(0, 4) == 0) lk.sz = lk.fz;
      end
      pending_links.push_back(lk);
      if (i == 120) begin
        wait_drained();
        pause_send = 1'b1;
        repeat (50) @(posedge clk);
        pause_send = 1'b0;
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
